>>> hdl/npcm_pkg.sv
// shared types, constants and helpers for the nearest palette colour mapper
`default_nettype none
package npcm_pkg;

  localparam int ChanW  = 8;
  localparam int IndexW = 8;
  localparam int CountW = 9;
  localparam int DistW  = 18;
  localparam int SqW    = 16;
  localparam int ColorW = 3 * ChanW;
  localparam int MaxSearch = 256;

  localparam logic [CountW-1:0] ActiveColorsReset = 9'd16;

  localparam logic ModeLoad = 1'b0;
  localparam logic ModeMap  = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              mode;
    logic [IndexW-1:0] entry_index;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic [IndexW-1:0] best_index;
    logic [DistW-1:0]  best_dist;
    logic [ColorW-1:0] best_color;
  } flow_t;

  function automatic logic [SqW-1:0] sq_diff(input logic [ChanW-1:0] a,
                                             input logic [ChanW-1:0] b);
    logic [ChanW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SqW'(d) * SqW'(d);
  endfunction

endpackage
`default_nettype wire

>>> hdl/nearest_palette_color_mapper.sv
// top level of the nearest palette colour mapper: config register and cell chain
`default_nettype none
// Maps 8-bit RGB pixels to the nearest loaded palette entry by squared distance,
// lowest index on a tie, and returns the index with the entry's colour. Items flow
// through a chain of min(PALETTE_DEPTH, 256) cells, each holding one entry; a
// load item writes its entry when it passes that cell, so items act in order.
// Each cell has two register stages (distance, then compare), and the chain takes
// one item per clock while the result is not stalled. A stalled result stops the
// whole chain. Load items give no result. The user must write active_colors through
// the cfg port only while no item is in flight; the block does not enforce this.
module nearest_palette_color_mapper
  import npcm_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CountW-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              mode,
  input  wire logic [IndexW-1:0] entry_index,
  input  wire logic [ChanW-1:0]  red,
  input  wire logic [ChanW-1:0]  green,
  input  wire logic [ChanW-1:0]  blue,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [IndexW-1:0]      palette_index,
  output logic [ChanW-1:0]       out_red,
  output logic [ChanW-1:0]       out_green,
  output logic [ChanW-1:0]       out_blue
);

  localparam int Cells = (PALETTE_DEPTH < MaxSearch) ? PALETTE_DEPTH : MaxSearch;
  localparam logic [CountW-1:0] Limit = CountW'(Cells);

  logic [CountW-1:0] active_colors;
  logic [CountW-1:0] count;
  logic              adv;
  flow_t             link [0:Cells];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_colors <= ActiveColorsReset;
    end else if (cfg_valid) begin
      active_colors <= cfg_data;
    end
  end

  always_comb begin
    if (active_colors == '0) begin
      count = CountW'(1);
    end else if (active_colors > Limit) begin
      count = Limit;
    end else begin
      count = active_colors;
    end
  end

  assign adv      = !(out_valid && !out_ready);
  assign in_ready = adv;

  always_comb begin
    link[0].valid       = in_valid;
    link[0].mode        = mode;
    link[0].entry_index = entry_index;
    link[0].red         = red;
    link[0].green       = green;
    link[0].blue        = blue;
    link[0].best_index  = '0;
    link[0].best_dist   = '0;
    link[0].best_color  = '0;
  end

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    npcm_cell #(
      .CELL_ID(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .count   (count),
      .cell_in (link[i]),
      .cell_out(link[i+1])
    );
  end

  assign out_valid     = link[Cells].valid && (link[Cells].mode == ModeMap);
  assign palette_index = link[Cells].best_index;
  assign out_red       = link[Cells].best_color[23:16];
  assign out_green     = link[Cells].best_color[15:8];
  assign out_blue      = link[Cells].best_color[7:0];

endmodule
`default_nettype wire

>>> hdl/npcm_cell.sv
// one palette cell: holds an entry, scores the passing pixel and keeps the best so far
`default_nettype none
module npcm_cell
  import npcm_pkg::*;
#(
  parameter int CELL_ID = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic [CountW-1:0] count,
  input  wire flow_t             cell_in,
  output flow_t                  cell_out
);

  localparam logic [IndexW-1:0] MyIndex = IndexW'(CELL_ID);
  localparam logic [CountW-1:0] MyCount = CountW'(CELL_ID);

  logic [ColorW-1:0] entry;
  flow_t             s1;
  logic [DistW-1:0]  s1_dist;
  logic [ColorW-1:0] s1_entry;
  logic [DistW-1:0]  cand_dist;
  logic              take;
  flow_t             s2_next;

  always_comb begin
    cand_dist = DistW'(sq_diff(cell_in.red,   entry[23:16]))
              + DistW'(sq_diff(cell_in.green, entry[15:8]))
              + DistW'(sq_diff(cell_in.blue,  entry[7:0]));
  end

  // entry write travels with the item stream so earlier pixels see the old colour
  always_ff @(posedge clk) begin
    if (adv && cell_in.valid && cell_in.mode == ModeLoad &&
        cell_in.entry_index == MyIndex) begin
      entry <= {cell_in.red, cell_in.green, cell_in.blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (adv) begin
      s1       <= cell_in;
      s1_dist  <= cand_dist;
      s1_entry <= entry;
    end
  end

  always_comb begin
    if (CELL_ID == 0) begin
      take = 1'b1;
    end else begin
      take = (MyCount < count) && (s1_dist < s1.best_dist);
    end
    s2_next = s1;
    if (s1.mode == ModeMap && take) begin
      s2_next.best_index = MyIndex;
      s2_next.best_dist  = s1_dist;
      s2_next.best_color = s1_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (adv) begin
      cell_out <= s2_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/npcm_checker.sv
// port-level checks for the nearest palette colour mapper, bound to the top level
`default_nettype none
module npcm_checker
  import npcm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [IndexW-1:0] palette_index,
  input wire logic [ChanW-1:0]  out_red,
  input wire logic [ChanW-1:0]  out_green,
  input wire logic [ChanW-1:0]  out_blue
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(palette_index) &&
      $stable(out_red) && $stable(out_green) && $stable(out_blue))
    else $error("result changed while stalled");

  // input is refused only while a result waits
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without output stall");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown after reset");

  // a stall on the output stops intake in the next cycle too, unless the result is taken then
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> !in_ready || out_ready)
    else $error("input taken while result stalled");

endmodule

bind nearest_palette_color_mapper npcm_checker u_npcm_checker (.*);
`default_nettype wire
